[hdl/ots_pkg.sv]
// Shared constants and types for the oldest-timestamp source tracker.
package ots_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 8;
  localparam int TIME_BITS = 48;
  localparam int IDX_BITS  = $clog2(ENTRIES);

  localparam logic MODE_SET    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ots_state_t;

  // Control from the sequencer to the shared min-search unit.
  typedef struct packed {
    logic start;       // first candidate of a scan: forget the previous best
    logic en;          // a candidate is presented this cycle
    logic cand_valid;  // the presented slot holds a source
  } ots_scan_ctl_t;

endpackage

[hdl/ots_min_unit.sv]
// Shared compare unit: tracks the smallest timestamp over a slot scan.
module ots_min_unit
  import ots_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ots_scan_ctl_t        ctl,
  input  logic [KEY_BITS-1:0]  cand_key,
  input  logic [TIME_BITS-1:0] cand_time,
  output logic                 best_found,
  output logic [KEY_BITS-1:0]  best_key,
  output logic [TIME_BITS-1:0] best_time
);

  logic                 found_r, found_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic                 have_best;
  logic                 take;

  // strict less-than keeps the lowest slot among equal timestamps
  assign have_best = found_r && !ctl.start;
  assign take      = ctl.en && ctl.cand_valid && (!have_best || (cand_time < time_r));

  always_comb begin
    found_nxt = found_r;
    key_nxt   = key_r;
    time_nxt  = time_r;
    if (ctl.en) begin
      found_nxt = have_best || ctl.cand_valid;
    end
    if (take) begin
      key_nxt  = cand_key;
      time_nxt = cand_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    time_r <= time_nxt;
  end

  assign best_found = found_r;
  assign best_key   = key_r;
  assign best_time  = time_r;

endmodule

[hdl/oldest_timestamp_source_tracker.sv]
// Top level of the oldest-timestamp source tracker.
//
// Keeps ENTRIES source slots, each a key and a timestamp. An accepted beat sets,
// updates or removes one source; the key lookup and the slot write happen at
// the accepting edge. One timestamp comparator then walks the slots, one per
// cycle, to find the oldest source (lowest slot wins ties), and the result is
// loaded into the output register. in_stall is low only in the idle state, so
// the input is held off through the scan and until the result is loaded. A
// finished result waits in the output register, so the next beat can be taken
// while it is stalled. An insert into a full table is dropped with status 1.
module oldest_timestamp_source_tracker
  import ots_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [KEY_BITS-1:0]  in_source_id,
  input  logic [TIME_BITS-1:0] in_new_timestamp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_changed,
  output logic                 out_active_present,
  output logic [KEY_BITS-1:0]  out_oldest_src,
  output logic [TIME_BITS-1:0] out_active_time,
  output logic                 out_status
);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

  ots_state_t state_r, state_nxt;

  logic [ENTRIES-1:0]   slot_valid_r;
  logic [KEY_BITS-1:0]  slot_key_r  [ENTRIES];
  logic [TIME_BITS-1:0] slot_time_r [ENTRIES];

  logic [IDX_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 status_r;
  logic                 active_valid_r;
  logic [KEY_BITS-1:0]  active_key_r;
  logic                 out_valid_r;

  logic                 accept;
  logic                 load_out;
  ots_scan_ctl_t        scan_ctl;

  logic                 hit;
  logic [IDX_BITS-1:0]  hit_idx;
  logic                 has_free;
  logic [IDX_BITS-1:0]  free_idx;

  logic                 best_found;
  logic [KEY_BITS-1:0]  best_key;
  logic [TIME_BITS-1:0] best_time;
  logic                 changed;

  assign accept = in_valid && !in_stall;

  // parallel key match and free-slot search, lowest slot first
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid_r[i] && (slot_key_r[i] == in_source_id)) begin
        hit     = 1'b1;
        hit_idx = IDX_BITS'(i);
      end
      if (!slot_valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IDX_BITS'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept)              state_nxt = ST_SCAN;
      ST_SCAN: if (cnt_r == LAST_IDX)   state_nxt = ST_DONE;
      ST_DONE: if (load_out)            state_nxt = ST_IDLE;
      default:                          state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall            = 1'b1;
    load_out            = 1'b0;
    scan_ctl.start      = 1'b0;
    scan_ctl.en         = 1'b0;
    scan_ctl.cand_valid = slot_valid_r[cnt_r];
    cnt_nxt             = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cnt_nxt  = '0;
      end
      ST_SCAN: begin
        scan_ctl.en    = 1'b1;
        scan_ctl.start = (cnt_r == '0);
        cnt_nxt        = cnt_r + 1'b1;
      end
      ST_DONE: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  ots_min_unit u_min (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .cand_key   (slot_key_r[cnt_r]),
    .cand_time  (slot_time_r[cnt_r]),
    .best_found (best_found),
    .best_key   (best_key),
    .best_time  (best_time)
  );

  assign changed = (best_found != active_valid_r) ||
                   (best_found && (best_key != active_key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      slot_valid_r   <= '0;
      active_valid_r <= 1'b0;
      active_key_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (accept) begin
        if (in_mode == MODE_SET) begin
          if (!hit && has_free) begin
            slot_valid_r[free_idx] <= 1'b1;
          end
        end else if (hit) begin
          slot_valid_r[hit_idx] <= 1'b0;
        end
      end
      if (load_out) begin
        active_valid_r <= best_found;
        active_key_r   <= best_found ? best_key : '0;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= STATUS_OK;
      if (in_mode == MODE_SET) begin
        if (hit) begin
          slot_time_r[hit_idx] <= in_new_timestamp;
        end else if (has_free) begin
          slot_key_r[free_idx]  <= in_source_id;
          slot_time_r[free_idx] <= in_new_timestamp;
        end else begin
          status_r <= STATUS_FULL;
        end
      end
    end
    if (load_out) begin
      out_changed        <= changed;
      out_active_present <= best_found;
      out_oldest_src     <= best_found ? best_key : '0;
      out_active_time    <= best_found ? best_time : '0;
      out_status         <= status_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/ots_checker.sv]
// Port-level checks for the oldest-timestamp source tracker, bound to the top.
module ots_checker
  import ots_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_changed,
  input logic                 out_active_present,
  input logic [KEY_BITS-1:0]  out_oldest_src,
  input logic [TIME_BITS-1:0] out_active_time,
  input logic                 out_status
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_active_time) &&
      $stable(out_oldest_src) && $stable(out_changed))
    else $error("stalled result beat changed");

  // empty table reports zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active_present |-> (out_oldest_src == '0) &&
      (out_active_time == '0))
    else $error("empty table result not zero");

  // a dropped insert leaves the table alone, so the active source cannot move
  a_full_nochange: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_FULL) |-> !out_changed &&
      out_active_present)
    else $error("dropped insert reported a change");

  // the scan keeps the input side busy after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted during scan");

endmodule

bind oldest_timestamp_source_tracker ots_checker u_ots_checker (.*);

[verif/oldest_timestamp_source_tracker_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the oldest-timestamp source tracker.
module oldest_timestamp_source_tracker_tb;
  import ots_pkg::*;

  typedef struct packed {
    logic                 changed;
    logic                 present;
    logic [KEY_BITS-1:0]  source;
    logic [TIME_BITS-1:0] stamp;
    logic                 status;
  } tracker_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_mode = MODE_SET;
  logic [KEY_BITS-1:0]  in_source_id = '0;
  logic [TIME_BITS-1:0] in_new_timestamp = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_changed;
  logic                 out_active_present;
  logic [KEY_BITS-1:0]  out_oldest_src;
  logic [TIME_BITS-1:0] out_active_time;
  logic                 out_status;

  // Shadow copy of the source table
  logic                 tracked_held   [ENTRIES];
  logic [KEY_BITS-1:0]  tracked_source [ENTRIES];
  logic [TIME_BITS-1:0] tracked_stamp  [ENTRIES];
  logic                 oldest_valid = 1'b0;
  logic [KEY_BITS-1:0]  oldest_source = '0;

  tracker_result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int changes_seen = 0;
  int inserts_dropped = 0;
  int removals_hit = 0;

  oldest_timestamp_source_tracker i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_source_id       (in_source_id),
    .in_new_timestamp   (in_new_timestamp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_changed        (out_changed),
    .out_active_present (out_active_present),
    .out_oldest_src     (out_oldest_src),
    .out_active_time    (out_active_time),
    .out_status         (out_status)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tracked_held[i]   = 1'b0;
      tracked_source[i] = '0;
      tracked_stamp[i]  = '0;
    end
  end

  // Applies one beat to the shadow table and returns the result it must produce.
  function automatic tracker_result_t track_oldest(logic mode, logic [KEY_BITS-1:0] src,
                                                   logic [TIME_BITS-1:0] stamp);
    tracker_result_t r;
    int hit;
    int free_slot;
    int best;
    hit = -1;
    free_slot = -1;
    best = -1;
    r = '0;
    r.status = STATUS_OK;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tracked_held[i] && tracked_source[i] == src && hit < 0) hit = i;
      if (!tracked_held[i] && free_slot < 0) free_slot = i;
    end
    if (mode == MODE_SET) begin
      if (hit >= 0) begin
        tracked_stamp[hit] = stamp;
      end else if (free_slot >= 0) begin
        tracked_held[free_slot]   = 1'b1;
        tracked_source[free_slot] = src;
        tracked_stamp[free_slot]  = stamp;
      end else begin
        r.status = STATUS_FULL;
        inserts_dropped++;
      end
    end else if (hit >= 0) begin
      tracked_held[hit] = 1'b0;
      removals_hit++;
    end
    // strict less-than keeps the lowest slot on ties
    for (int i = 0; i < ENTRIES; i++) begin
      if (tracked_held[i] && (best < 0 || tracked_stamp[i] < tracked_stamp[best])) best = i;
    end
    r.present = (best >= 0);
    if (r.present) begin
      r.source = tracked_source[best];
      r.stamp  = tracked_stamp[best];
    end
    r.changed = (r.present != oldest_valid) || (r.present && r.source != oldest_source);
    oldest_valid  = r.present;
    oldest_source = r.source;
    if (r.changed) changes_seen++;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < 40) begin
      $display("MISMATCH result %0d: %s got %0h want %0h", results_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic send_beat(logic mode, logic [KEY_BITS-1:0] src, logic [TIME_BITS-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_source_id     <= src;
    in_new_timestamp <= stamp;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_results.push_back(track_oldest(mode, src, stamp));
    beats_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    tracker_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, source", out_oldest_src, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_changed !== want.changed)
          report_mismatch("changed", out_changed, want.changed);
        if (out_active_present !== want.present)
          report_mismatch("active_present", out_active_present, want.present);
        if (out_oldest_src !== want.source)
          report_mismatch("oldest_src", out_oldest_src, want.source);
        if (out_active_time !== want.stamp)
          report_mismatch("active_time", out_active_time, want.stamp);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
      results_seen++;
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Empty table, extreme keys and stamps, ties, removal of absent keys.
  task automatic test_empty_table_and_ties();
    send_beat(MODE_REMOVE, 8'h55, '1);
    send_beat(MODE_SET, 8'h00, '1);
    send_beat(MODE_SET, 8'hFF, '0);
    send_beat(MODE_SET, 8'hAA, '0);   // tie at zero: the earlier slot stays active
    send_beat(MODE_REMOVE, 8'hFF, '0);
    send_beat(MODE_REMOVE, 8'hAA, '1);
  endtask

  // Fill every slot, overflow, update and refill while full.
  task automatic test_full_table();
    for (int k = 1; k < ENTRIES; k++) begin
      send_beat(MODE_SET, KEY_BITS'(k), TIME_BITS'(48'h8000_0000_0000 - k));
    end
    send_beat(MODE_SET, 8'h80, 48'h1);        // dropped
    send_beat(MODE_SET, 8'h03, '0);           // update of a held key while full
    send_beat(MODE_REMOVE, 8'h99, '0);        // absent
    send_beat(MODE_REMOVE, 8'h07, '0);
    send_beat(MODE_SET, 8'hC3, '0);           // refills slot 7, loses the tie to slot 3
  endtask

  task automatic random_beat(int set_pct);
    logic                 mode;
    logic [KEY_BITS-1:0]  src;
    logic [TIME_BITS-1:0] stamp;
    logic [63:0]          wide;
    mode = ($urandom_range(99) < set_pct) ? MODE_SET : MODE_REMOVE;
    // a small key pool keeps hits and a full table common
    if ($urandom_range(99) < 75) src = KEY_BITS'($urandom_range(0, 23));
    else src = KEY_BITS'($urandom_range(0, 255));
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       stamp = '0;
      1:       stamp = '1;
      2, 3, 4: stamp = TIME_BITS'($urandom_range(0, 7));
      default: stamp = wide[TIME_BITS-1:0];
    endcase
    send_beat(mode, src, stamp);
  endtask

  task automatic test_random_traffic(int count);
    int set_pct;
    set_pct = 50;
    for (int n = 0; n < count; n++) begin
      // swing the insert bias so occupancy sweeps from empty to full
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       set_pct = 30;
          1:       set_pct = 50;
          2:       set_pct = 70;
          default: set_pct = 85;
        endcase
      end
      random_beat(set_pct);
    end
  endtask

  // One beat in flight at a time: the sender holds off until all results are back.
  task automatic test_drain_pause();
    for (int n = 0; n < 10; n++) begin
      wait_for_drain();
      random_beat(60);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 60;
    test_empty_table_and_ties();
    test_full_table();
    test_random_traffic(400);
    test_drain_pause();

    send_idle_pct = 60;
    recv_idle_pct = 35;
    test_random_traffic(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(400);

    wait_for_drain();
    repeat (40) @(posedge clk);

    $display("Ran %0d beats (%0d results): %0d oldest-source changes,", beats_sent,
             results_seen, changes_seen);
    $display("%0d inserts dropped on a full table, %0d removals of held sources.",
             inserts_dropped, removals_hit);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
